### design/psag_pkg.sv
// psag_pkg: shared types, constants and the sine lookup for the scanline affine generator
package psag_pkg;

  // field widths
  localparam int LINE_W     = 8;
  localparam int STEP_W     = 16;
  localparam int ORIGIN_W   = 28;
  localparam int CFG_DATA_W = 19;
  localparam int SINE_W     = 10;
  localparam int FRAC       = 8;

  // divider shape: quotient bits below the scale limit, bits resolved per stage
  localparam int QUOT_W        = 14;
  localparam int DIV_STEP_BITS = 2;
  localparam int DIV_STAGES    = QUOT_W / DIV_STEP_BITS;
  localparam int SCALE_W       = QUOT_W + 1;
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 15'h4000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAM_X          = 3'd0,
    CFG_CAM_Y          = 3'd1,
    CFG_VIEW_ANGLE     = 3'd2,
    CFG_CAM_HEIGHT     = 3'd3,
    CFG_FOCAL_DEPTH    = 3'd4,
    CFG_HORIZON_LINE   = 3'd5,
    CFG_PERSPECTIVE_ON = 3'd6
  } cfg_index_t;

  // live configuration plus the sine and cosine of the view angle
  typedef struct packed {
    logic signed [18:0]       cam_x;
    logic signed [18:0]       cam_y;
    logic [7:0]               view_angle;
    logic [13:0]              cam_height;
    logic [11:0]              focal_depth;
    logic [7:0]               horizon_line;
    logic                     perspective_on;
    logic signed [SINE_W-1:0] sin_v;
    logic signed [SINE_W-1:0] cos_v;
  } cfg_t;

  // one line travelling through the divider
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [7:0]        span;
    logic              clamp;
    logic [7:0]        rem;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] dvd;
  } div_t;

  // first quadrant of a Q8 sine, 65 points
  localparam logic [8:0] QUARTER_SINE [65] = '{
    9'd0,   9'd6,   9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,
    9'd50,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
    9'd98,  9'd104, 9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137,
    9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd172, 9'd177,
    9'd181, 9'd185, 9'd190, 9'd194, 9'd198, 9'd202, 9'd206, 9'd209,
    9'd213, 9'd216, 9'd220, 9'd223, 9'd226, 9'd229, 9'd231, 9'd234,
    9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247, 9'd248, 9'd250,
    9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256, 9'd256,
    9'd256
  };

  // full-turn sine from the quarter table, 256 steps per turn
  function automatic logic signed [SINE_W-1:0] sine_q8(input logic [7:0] angle);
    logic [5:0]               idx;
    logic [6:0]               addr;
    logic signed [SINE_W-1:0] mag;
    idx  = angle[5:0];
    addr = angle[6] ? 7'(7'd64 - {1'b0, idx}) : {1'b0, idx};
    mag  = $signed({1'b0, QUARTER_SINE[addr]});
    return angle[7] ? -mag : mag;
  endfunction

endpackage

### design/psag_ifs.sv
// psag channel interfaces: configuration writes, line requests, line parameters

interface psag_cfg_if;
  logic                                valid;
  logic                                ready;
  psag_pkg::cfg_index_t                index;
  logic [psag_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface psag_line_if;
  logic                            valid;
  logic                            ready;
  logic [psag_pkg::LINE_W-1:0]     line_index;
  modport source (output valid, line_index, input ready);
  modport sink   (input valid, line_index, output ready);
endinterface

interface psag_param_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [psag_pkg::STEP_W-1:0]    step_dx;
  logic signed [psag_pkg::STEP_W-1:0]    step_dy;
  logic signed [psag_pkg::ORIGIN_W-1:0]  origin_x;
  logic signed [psag_pkg::ORIGIN_W-1:0]  origin_y;
  modport source (output valid, step_dx, step_dy, origin_x, origin_y, input ready);
  modport sink   (input valid, step_dx, step_dy, origin_x, origin_y, output ready);
endinterface

### design/psag_cfg.sv
// psag_cfg: configuration register file and view angle sine/cosine lookup
module psag_cfg (
  input  logic           clk,
  input  logic           rst,
  psag_cfg_if.sink       wr,
  output psag_pkg::cfg_t regs
);

  logic signed [18:0] cam_x;
  logic signed [18:0] cam_y;
  logic [7:0]         view_angle;
  logic [13:0]        cam_height;
  logic [11:0]        focal_depth;
  logic [7:0]         horizon_line;
  logic               perspective_on;

  // writes are always taken
  assign wr.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x          <= '0;
      cam_y          <= '0;
      view_angle     <= '0;
      cam_height     <= 14'd120;
      focal_depth    <= 12'd160;
      horizon_line   <= 8'd40;
      perspective_on <= 1'b1;
    end else if (wr.valid) begin
      unique case (wr.index)
        psag_pkg::CFG_CAM_X:          cam_x          <= $signed(wr.data);
        psag_pkg::CFG_CAM_Y:          cam_y          <= $signed(wr.data);
        psag_pkg::CFG_VIEW_ANGLE:     view_angle     <= wr.data[7:0];
        psag_pkg::CFG_CAM_HEIGHT:     cam_height     <= wr.data[13:0];
        psag_pkg::CFG_FOCAL_DEPTH:    focal_depth    <= wr.data[11:0];
        psag_pkg::CFG_HORIZON_LINE:   horizon_line   <= wr.data[7:0];
        psag_pkg::CFG_PERSPECTIVE_ON: perspective_on <= wr.data[0];
        default: ;
      endcase
    end
  end

  // packed view for the datapath, cos(a) = sin(a + quarter turn)
  always_comb begin
    regs.cam_x          = cam_x;
    regs.cam_y          = cam_y;
    regs.view_angle     = view_angle;
    regs.cam_height     = cam_height;
    regs.focal_depth    = focal_depth;
    regs.horizon_line   = horizon_line;
    regs.perspective_on = perspective_on;
    regs.sin_v          = psag_pkg::sine_q8(view_angle);
    regs.cos_v          = psag_pkg::sine_q8(8'(view_angle + 8'd64));
  end

endmodule

### design/psag_div_stage.sv
// psag_div_stage: one pipelined restoring-division stage, two quotient bits per beat
module psag_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  psag_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output psag_pkg::div_t out_data
);

  psag_pkg::div_t nxt;
  logic [8:0]     trial;

  // shift in dividend bits, subtract the divisor where it fits
  always_comb begin
    nxt   = in_data;
    trial = '0;
    for (int b = 0; b < psag_pkg::DIV_STEP_BITS; b++) begin
      trial    = {nxt.rem, nxt.dvd[psag_pkg::QUOT_W-1]};
      nxt.dvd  = nxt.dvd << 1;
      if (trial >= {1'b0, nxt.span}) begin
        nxt.rem  = 8'(trial - {1'b0, nxt.span});
        nxt.quot = {nxt.quot[psag_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = trial[7:0];
        nxt.quot = {nxt.quot[psag_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

  // stage register, empty or draining slot takes a new beat
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

### design/psag_math.sv
// psag_math: scale, rotation and origin arithmetic in three register stages
module psag_math #(
  parameter int SCREEN_LINES   = 160,
  parameter int SCREEN_COLUMNS = 240
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  psag_pkg::div_t in_data,
  input  psag_pkg::cfg_t regs,
  psag_param_if.source   params
);

  localparam int HC      = SCREEN_COLUMNS / 2;
  localparam int HL      = SCREEN_LINES / 2;
  localparam int HC_W    = $clog2(HC + 1) + 1;
  localparam int HL_W    = $clog2(HL + 1) + 1;
  localparam logic signed [HC_W-1:0] HALF_COLS  = HC_W'(HC);
  localparam logic signed [HL_W-1:0] HALF_LINES = HL_W'(HL);

  localparam int SW     = psag_pkg::SINE_W;
  localparam int OW     = psag_pkg::ORIGIN_W;
  localparam int FR     = psag_pkg::FRAC;
  localparam int PDX_W  = psag_pkg::SCALE_W + 1 + SW;
  localparam int DX_W   = PDX_W - FR;
  localparam int PADV_W = 12 + psag_pkg::SCALE_W;
  localparam int ADV_W  = PADV_W - FR;
  localparam int PAS_W  = ADV_W + 1 + SW;
  localparam int LS_W   = psag_pkg::LINE_W + 1;

  logic v1;
  logic v2;
  logic r1;
  logic r2;
  logic r3;

  // stage 1 products
  logic signed [PDX_W-1:0]     p_dx;
  logic signed [PDX_W-1:0]     p_dy;
  logic [PADV_W-1:0]           p_adv;
  logic signed [SW+HC_W-1:0]   f_cc;
  logic signed [SW+HC_W-1:0]   f_sc;
  logic signed [SW+HL_W-1:0]   f_cl;
  logic signed [SW+HL_W-1:0]   f_sl;
  logic signed [SW+LS_W-1:0]   f_cy;
  logic signed [SW+LS_W-1:0]   f_sy;

  // stage 2 products and flat-mode origins
  logic signed [DX_W-1:0]      dx;
  logic signed [DX_W-1:0]      dy;
  logic signed [PAS_W-1:0]     p_as;
  logic signed [PAS_W-1:0]     p_ac;
  logic signed [DX_W+HC_W-1:0] p_dxc;
  logic signed [DX_W+HC_W-1:0] p_dyc;
  logic signed [OW-1:0]        ox_f;
  logic signed [OW-1:0]        oy_f;

  // combinational helpers
  logic [psag_pkg::SCALE_W-1:0]   scale;
  logic signed [psag_pkg::SCALE_W:0] scale_s;
  logic signed [LS_W-1:0]          line_s;
  logic signed [OW-1:0]            base_x;
  logic signed [OW-1:0]            base_y;
  logic signed [DX_W-1:0]          dx_n;
  logic signed [DX_W-1:0]          dy_n;
  logic signed [ADV_W:0]           adv_s;

  always_comb begin
    scale   = in_data.clamp ? psag_pkg::SCALE_LIMIT : {1'b0, in_data.quot};
    scale_s = $signed({1'b0, scale});
    line_s  = $signed({1'b0, in_data.line});
    base_x  = OW'($signed({regs.cam_x, 8'h00}));
    base_y  = OW'($signed({regs.cam_y, 8'h00}));
    // arithmetic shift by the fraction: drop the low bits of the signed product
    dx_n    = $signed(p_dx[PDX_W-1:FR]);
    dy_n    = $signed(p_dy[PDX_W-1:FR]);
    adv_s   = $signed({1'b0, p_adv[PADV_W-1:FR]});
  end

  // per-stage handshake
  assign r3       = !params.valid || params.ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      params.valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) params.valid <= v2;
    end
  end

  // stage 1: scale times sine/cosine, focal advance, flat-mode terms
  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      p_dx  <= scale_s * regs.cos_v;
      p_dy  <= scale_s * regs.sin_v;
      p_adv <= regs.focal_depth * scale;
      f_cc  <= regs.cos_v * HALF_COLS;
      f_sc  <= regs.sin_v * HALF_COLS;
      f_cl  <= regs.cos_v * HALF_LINES;
      f_sl  <= regs.sin_v * HALF_LINES;
      f_cy  <= regs.cos_v * line_s;
      f_sy  <= regs.sin_v * line_s;
    end
  end

  // stage 2: rotate the advance, center the steps, sum flat origins
  always_ff @(posedge clk) begin
    if (v1 && r2) begin
      dx    <= dx_n;
      dy    <= dy_n;
      p_as  <= adv_s * regs.sin_v;
      p_ac  <= adv_s * regs.cos_v;
      p_dxc <= dx_n * HALF_COLS;
      p_dyc <= dy_n * HALF_COLS;
      ox_f  <= base_x - OW'(f_cc) + OW'(f_sl) - OW'(f_sy);
      oy_f  <= base_y - OW'(f_sc) - OW'(f_cl) + OW'(f_cy);
    end
  end

  // stage 3: output register, mode select
  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      if (regs.perspective_on) begin
        params.step_dx  <= dx[psag_pkg::STEP_W-1:0];
        params.step_dy  <= dy[psag_pkg::STEP_W-1:0];
        params.origin_x <= base_x - OW'($signed(p_as[PAS_W-1:FR])) - OW'(p_dxc);
        params.origin_y <= base_y + OW'($signed(p_ac[PAS_W-1:FR])) - OW'(p_dyc);
      end else begin
        params.step_dx  <= psag_pkg::STEP_W'(regs.cos_v);
        params.step_dy  <= psag_pkg::STEP_W'(regs.sin_v);
        params.origin_x <= ox_f;
        params.origin_y <= oy_f;
      end
    end
  end

endmodule

### design/perspective_scanline_affine_gen_unit.sv
// Usage: per-scanline affine parameters (steps and line origin) for a rotating ground plane.
// Channels: cfg writes one of seven registers (index, data); it is always ready and a write
// takes effect on the next cycle. Write it only while no line is in flight. lines carries a
// scanline index in; params returns step_dx, step_dy (8.8) and origin_x, origin_y (20.8).
// Pipeline: one input register, seven divider stages and three multiply/sum stages lie
// between an accepted line beat and its params beat.
// Throughput: one line per cycle unless params stalls; every stage is registered and the
// perspective scale divide resolves two quotient bits per stage, so a line may enter each cycle.
// Reset (rst, synchronous): all stage valids clear, registers return to camera at the
// origin, angle 0, height 120, focal depth 160, horizon 40, perspective mode.
// Stall: when params is not taken, each stage holds its beat; lines.ready stays high while
// any stage slot is free and drops only when all eleven stages hold a beat.
module perspective_scanline_affine_gen_unit #(
  parameter int SCREEN_LINES   = 160,
  parameter int SCREEN_COLUMNS = 240
) (
  input  logic          clk,
  input  logic          rst,
  psag_cfg_if.sink      cfg,
  psag_line_if.sink     lines,
  psag_param_if.source  params
);

  localparam int DS = psag_pkg::DIV_STAGES;

  psag_pkg::cfg_t cfg_q;
  psag_pkg::div_t in_d;
  psag_pkg::div_t in_q;
  logic           in_v;

  logic signed [8:0] span_s;
  logic [7:0]        span;

  logic           dv [DS+1];
  logic           dr [DS+1];
  psag_pkg::div_t dd [DS+1];

  // configuration registers
  psag_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg),
    .regs (cfg_q)
  );

  // distance below horizon, floored at one; clamp when height*256 / span >= limit
  always_comb begin
    span_s     = $signed({1'b0, lines.line_index}) - $signed({1'b0, cfg_q.horizon_line});
    span       = (span_s < 9'sd1) ? 8'd1 : span_s[7:0];
    in_d.line  = lines.line_index;
    in_d.span  = span;
    in_d.clamp = cfg_q.cam_height >= {span, 6'b0};
    in_d.rem   = cfg_q.cam_height[13:6];
    in_d.quot  = '0;
    in_d.dvd   = {cfg_q.cam_height[5:0], 8'h00};
  end

  // input register
  assign lines.ready = !in_v || dr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (lines.ready) begin
      in_v <= lines.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lines.valid && lines.ready) begin
      in_q <= in_d;
    end
  end

  assign dv[0] = in_v;
  assign dd[0] = in_q;

  // divider pipeline
  for (genvar g = 0; g < DS; g++) begin : g_div
    psag_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_data   (dd[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_data  (dd[g+1])
    );
  end

  // steps and origins
  psag_math #(
    .SCREEN_LINES   (SCREEN_LINES),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_math (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dv[DS]),
    .in_ready (dr[DS]),
    .in_data  (dd[DS]),
    .regs     (cfg_q),
    .params   (params)
  );

`ifndef SYNTHESIS
  // input backpressure only when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !lines.ready |-> params.valid && !params.ready)
    else $error("lines not ready while pipeline has room");

  // unclamped quotient leaving the divider satisfies q*d <= n < (q+1)*d
  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    dv[DS] && !dd[DS].clamp |->
      (22'(dd[DS].quot) * 22'(dd[DS].span) <= {cfg_q.cam_height, 8'h00}) &&
      (({cfg_q.cam_height, 8'h00} - 22'(dd[DS].quot) * 22'(dd[DS].span))
        < 22'(dd[DS].span)))
    else $error("divider quotient out of range");

  // flat mode steps are the plain cosine and sine of the view angle
  a_flat_steps: assert property (@(posedge clk) disable iff (rst)
    params.valid && !cfg_q.perspective_on |->
      params.step_dx == psag_pkg::STEP_W'(cfg_q.cos_v) &&
      params.step_dy == psag_pkg::STEP_W'(cfg_q.sin_v))
    else $error("flat mode steps do not match rotation");
`endif

endmodule
